// File: src/tposm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tposm_pkg
// Shared constants and types for the two-pass one-pole smoother.
// ----------------------------------------------------------------------------
package tposm_pkg;

   localparam int SAMPLE_BITS_DEF    = 16;
   localparam int GAIN_FRAC_BITS_DEF = 16;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_ACC  = 5'b00100,
      ST_OUT1 = 5'b01000,
      ST_OUT2 = 5'b10000
   } state_type;

   // which blend the shared unit is working on
   typedef enum logic [1:0] {
      OP_TAP  = 2'd0,   // held sample with its successor
      OP_POLE = 2'd1,   // stage-one value with previous output
      OP_LAST = 2'd2    // last sample of frame with previous output
   } op_type;

endpackage
`default_nettype wire

// File: src/two_pass_one_pole_smoother.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_pass_one_pole_smoother
// Framed sample smoother: two-tap blend followed by a one-pole recursion,
// all products through one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* channel takes one sample item with its frame_end flag.
//  - rsp_* channel returns smoothed items; the final one of a frame carries
//    rsp_last_of_frame. One sample is held back, so the first item of a frame
//    gives nothing and the frame_end item gives two results.
//  - csr_* channel writes the gain (Q1.GAIN_FRAC_BITS, clamped to one); it is
//    always ready; the user must write it only while the block is idle, and
//    the block itself does not enforce this.
//  - Each blend passes the shared multiply/round unit as a multiply state, then
//    an add, round and saturate state. A mid-frame item needs 1 or 2 blends, a
//    frame_end item 2 or 3, and a one-sample frame or the first item of a frame
//    none. req_ready is high only in the idle state.
//  - Results leave through one output register; a stalled receiver holds the
//    sequencer in its output state until the register frees up, and a new
//    item may be taken while the last result still waits.
//  - Synchronous reset returns gain to one half, drops any held sample and
//    clears rsp_valid.
// ----------------------------------------------------------------------------
module two_pass_one_pole_smoother #(
   parameter int SAMPLE_BITS    = tposm_pkg::SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = tposm_pkg::GAIN_FRAC_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   // input items
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [SAMPLE_BITS-1:0]       req_sample,
   input  wire                          req_frame_end,
   // result items
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [SAMPLE_BITS-1:0]       rsp_smoothed,
   output logic                         rsp_last_of_frame,
   // gain register
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [GAIN_FRAC_BITS:0]      csr_gain
);

   localparam int S  = SAMPLE_BITS;
   localparam int G  = GAIN_FRAC_BITS;
   localparam int PW = S + G + 3;

   localparam logic [G:0]          GAIN_ONE  = {1'b1, {G{1'b0}}};
   localparam logic [G:0]          GAIN_HALF = {2'b01, {(G-1){1'b0}}};
   localparam logic [PW-1:0]       ROUND_HALF = {{(PW-G){1'b0}}, 1'b1, {(G-1){1'b0}}};
   localparam logic signed [S+2:0] SAT_MAX = {4'b0000, {(S-1){1'b1}}};
   localparam logic signed [S+2:0] SAT_MIN = {4'b1111, {(S-1){1'b0}}};

   // ------------------------------------------------------------------------
   // registers
   tposm_pkg::state_type  state_ff, state_in;
   tposm_pkg::op_type     op_ff, op_in;
   logic [G:0]            gain_ff, gain_in;
   logic [S-1:0]          held_ff, held_in;
   logic                  held_valid_ff, held_valid_in;
   logic                  first_ff, first_in;
   logic [S-1:0]          prev_ff, prev_in;
   logic [S-1:0]          x_ff, x_in;
   logic                  end_ff, end_in;
   logic [S-1:0]          res_ff, res_in;
   logic signed [PW-1:0]  prod_ff, prod_in;
   logic [S-1:0]          b_ff, b_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [S-1:0]          rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   // ------------------------------------------------------------------------
   // shared blend unit: a*k + b*(1-k) = b*ONE + k*(a-b)
   logic [S-1:0]          op_a, op_b;
   logic signed [S:0]     diff;
   logic signed [G+1:0]   gain_s;
   logic signed [PW-1:0]  acc;
   logic signed [S+2:0]   acc_q;
   logic [S-1:0]          blend_res;

   always_comb begin
      case (op_ff)
         tposm_pkg::OP_TAP: begin
            op_a = held_ff;
            op_b = x_ff;
         end
         tposm_pkg::OP_POLE: begin
            op_a = res_ff;
            op_b = prev_ff;
         end
         default: begin
            op_a = x_ff;
            op_b = prev_ff;
         end
      endcase
   end

   assign diff    = $signed({op_a[S-1], op_a}) - $signed({op_b[S-1], op_b});
   assign gain_s  = $signed({1'b0, gain_ff});
   assign prod_in = diff * gain_s;
   assign b_in    = op_b;

   assign acc   = $signed({{3{b_ff[S-1]}}, b_ff, {G{1'b0}}}) + prod_ff
                  + $signed(ROUND_HALF);
   assign acc_q = acc[PW-1:G];   // floor after adding one half

   always_comb begin
      if (acc_q > SAT_MAX) begin
         blend_res = SAT_MAX[S-1:0];
      end else if (acc_q < SAT_MIN) begin
         blend_res = SAT_MIN[S-1:0];
      end else begin
         blend_res = acc_q[S-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // sequencer
   logic out_free;
   logic req_take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == tposm_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      gain_in       = gain_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      first_in      = first_ff;
      prev_in       = prev_ff;
      x_in          = x_ff;
      end_in        = end_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid) begin
         gain_in = (csr_gain > GAIN_ONE) ? GAIN_ONE : csr_gain;
      end

      case (state_ff)
         tposm_pkg::ST_IDLE: begin
            if (req_take) begin
               x_in   = req_sample;
               end_in = req_frame_end;
               if (held_valid_ff) begin
                  op_in    = tposm_pkg::OP_TAP;
                  state_in = tposm_pkg::ST_MUL;
               end else if (!req_frame_end) begin
                  // first item of a frame: just hold it
                  held_in       = req_sample;
                  held_valid_in = 1'b1;
               end else begin
                  // one-sample frame passes straight through
                  res_in   = req_sample;
                  state_in = tposm_pkg::ST_OUT2;
               end
            end
         end
         tposm_pkg::ST_MUL: begin
            state_in = tposm_pkg::ST_ACC;
         end
         tposm_pkg::ST_ACC: begin
            res_in = blend_res;
            case (op_ff)
               tposm_pkg::OP_TAP: begin
                  if (first_ff) begin
                     state_in = tposm_pkg::ST_OUT1;
                  end else begin
                     op_in    = tposm_pkg::OP_POLE;
                     state_in = tposm_pkg::ST_MUL;
                  end
               end
               tposm_pkg::OP_POLE: begin
                  state_in = tposm_pkg::ST_OUT1;
               end
               default: begin
                  state_in = tposm_pkg::ST_OUT2;
               end
            endcase
         end
         tposm_pkg::ST_OUT1: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_last_in  = 1'b0;
               prev_in      = res_ff;
               first_in     = 1'b0;
               if (end_ff) begin
                  op_in    = tposm_pkg::OP_LAST;
                  state_in = tposm_pkg::ST_MUL;
               end else begin
                  held_in       = x_ff;
                  held_valid_in = 1'b1;
                  state_in      = tposm_pkg::ST_IDLE;
               end
            end
         end
         tposm_pkg::ST_OUT2: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_ff;
               rsp_last_in   = 1'b1;
               prev_in       = res_ff;
               held_valid_in = 1'b0;
               first_in      = 1'b1;
               state_in      = tposm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tposm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tposm_pkg::ST_IDLE;
         op_ff         <= tposm_pkg::OP_TAP;
         gain_ff       <= GAIN_HALF;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         first_ff      <= 1'b1;
         prev_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         gain_ff       <= gain_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         first_ff      <= first_in;
         prev_ff       <= prev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      end_ff      <= end_in;
      res_ff      <= res_in;
      prod_ff     <= prod_in;
      b_ff        <= b_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_smoothed      = rsp_data_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule
`default_nettype wire

// File: dv/tb_two_pass_one_pole_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_pass_one_pole_smoother
// Self-checking bench for the framed two-pass smoother. A behavioral model of
// the tap blend and one-pole recursion predicts every result item. Results
// are checked in order against the model; in some tests both channels idle
// at random. Gain steps through extremes and random settings between frames.
// ----------------------------------------------------------------------------
module tb_two_pass_one_pole_smoother;

   localparam int SB = tposm_pkg::SAMPLE_BITS_DEF;
   localparam int GF = tposm_pkg::GAIN_FRAC_BITS_DEF;
   localparam longint GAIN_ONE   = longint'(1) << GF;
   localparam longint SAMPLE_MAX = (longint'(1) << (SB - 1)) - 1;
   localparam longint SAMPLE_MIN = -(longint'(1) << (SB - 1));
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 2000;

   typedef struct {
      logic signed [SB-1:0] smoothed;
      logic                 last_of_frame;
   } smoothed_item_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [SB-1:0] req_sample;
   logic req_frame_end;
   logic rsp_valid;
   logic rsp_ready;
   logic [SB-1:0] rsp_smoothed;
   logic rsp_last_of_frame;
   logic csr_valid;
   logic csr_ready;
   logic [GF:0] csr_gain;

   // model state
   longint gain_k;
   logic signed [SB-1:0] held_x;
   logic held_ok;
   logic held_first;
   logic signed [SB-1:0] last_y;
   smoothed_item_type smoothed_q[$];

   // knobs and counters
   bit src_gaps;
   bit sink_stalls;
   bit long_hold;
   int errors;
   int items_in;
   int results_out;
   int frames_sent;
   int gain_writes;
   int idle_cycles;

   two_pass_one_pole_smoother dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_smoothed      (rsp_smoothed),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_gain          (csr_gain)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // a*k + b*(one-k), round half up, saturate
   function automatic logic signed [SB-1:0] blend_q(input longint a, input longint b);
      longint acc;
      longint r;
      acc = gain_k * a + (GAIN_ONE - gain_k) * b + (longint'(1) << (GF - 1));
      r = acc >>> GF;
      if (r > SAMPLE_MAX)
         r = SAMPLE_MAX;
      else if (r < SAMPLE_MIN)
         r = SAMPLE_MIN;
      return r[SB-1:0];
   endfunction

   function automatic void predict_smoother(input logic signed [SB-1:0] x, input logic fe);
      logic signed [SB-1:0] r;
      logic signed [SB-1:0] y;
      if (held_ok) begin
         r = blend_q(held_x, x);
         y = held_first ? r : blend_q(r, last_y);
         last_y = y;
         held_first = 1'b0;
         smoothed_q.push_back('{y, 1'b0});
      end
      if (!fe) begin
         held_x = x;
         held_ok = 1'b1;
      end else begin
         // last sample has no successor: its stage-one value is itself
         y = held_first ? x : blend_q(x, last_y);
         last_y = y;
         smoothed_q.push_back('{y, 1'b1});
         held_ok = 1'b0;
         held_first = 1'b1;
      end
   endfunction

   function automatic logic signed [SB-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX[SB-1:0];
         1: return SAMPLE_MIN[SB-1:0];
         2: return SB'($urandom_range(0, 8) - 4);
         default: return SB'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic signed [SB-1:0] x, input logic fe);
      @(negedge clock);
      if (src_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample    <= x;
      req_frame_end <= fe;
      do @(posedge clock); while (!req_ready);
      predict_smoother(x, fe);
      items_in++;
   endtask

   task automatic send_frame(input int len);
      for (int i = 0; i < len; i++)
         send_sample(rand_sample(), i == len - 1);
      frames_sent++;
   endtask

   // drop valid, drain, and let the sequencer finish any silent item
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (smoothed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_gain(input logic [GF:0] g);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_gain  <= g;
      do @(posedge clock); while (!csr_ready);
      gain_k = (longint'(g) > GAIN_ONE) ? GAIN_ONE : longint'(g);
      gain_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_frame_len();
      case ($urandom_range(0, 9))
         0: return 1;
         8: return $urandom_range(9, 24);
         9: return $urandom_range(25, 60);
         default: return $urandom_range(2, 8);
      endcase
   endfunction

   // gain at its reset value of one half, rounding ties and extremes
   task automatic test_reset_gain_frames();
      send_sample(SAMPLE_MAX[SB-1:0], 1'b1);
      send_sample(SAMPLE_MIN[SB-1:0], 1'b1);
      send_sample(16'sd1, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd0, 1'b1);
      send_sample(SAMPLE_MAX[SB-1:0], 1'b0);
      send_sample(SAMPLE_MIN[SB-1:0], 1'b0);
      send_sample(SAMPLE_MAX[SB-1:0], 1'b1);
      frames_sent += 4;
      settle_block();
   endtask

   // zero, one, over one (clamped), smallest step, just under one
   task automatic test_gain_extremes();
      logic [GF:0] gain_set [5];
      gain_set = '{'0, GAIN_ONE[GF:0], {(GF+1){1'b1}}, (GF+1)'(1),
                   GAIN_ONE[GF:0] - 1'b1};
      foreach (gain_set[i]) begin
         write_gain(gain_set[i]);
         send_sample(SAMPLE_MIN[SB-1:0], 1'b0);
         send_sample(SAMPLE_MAX[SB-1:0], 1'b0);
         send_sample(SAMPLE_MIN[SB-1:0], 1'b1);
         frames_sent++;
         settle_block();
      end
   endtask

   task automatic test_random_frames();
      logic [GF:0] g;
      int start;
      src_gaps = 1;
      sink_stalls = 1;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: g = (GF+1)'($urandom_range(0, GAIN_ONE));
            1: g = (GF+1)'($urandom_range(GAIN_ONE, (1 << (GF + 1)) - 1));
            2: g = (GF+1)'($urandom_range(1, 2000));
            3: g = (GF+1)'($urandom_range(GAIN_ONE - 2000, GAIN_ONE - 1));
            default: g = (GF+1)'($urandom);
         endcase
         write_gain(g);
         start = items_in;
         while (items_in - start < 100)
            send_frame(pick_frame_len());
         settle_block();
      end
   endtask

   // receiver holds off for a long stretch while items keep coming
   task automatic test_output_backpressure();
      src_gaps = 0;
      sink_stalls = 1;
      write_gain((GF+1)'($urandom_range(0, GAIN_ONE)));
      long_hold = 1'b1;
      send_frame(24);
      send_frame(6);
      settle_block();
   endtask

   task automatic test_full_rate();
      src_gaps = 0;
      sink_stalls = 0;
      write_gain((GF+1)'($urandom_range(0, GAIN_ONE)));
      for (int i = 0; i < 12; i++)
         send_frame($urandom_range(1, 10));
      settle_block();
   endtask

   // result side: random stall bursts, one long hold on request
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      smoothed_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_out++;
         if (smoothed_q.size() == 0) begin
            errors++;
            $display("%0t: result with none pending: smoothed %0d last %0b",
                     $time, $signed(rsp_smoothed), rsp_last_of_frame);
         end else begin
            want = smoothed_q.pop_front();
            if (rsp_smoothed !== want.smoothed) begin
               errors++;
               $display("%0t: smoothed expected %0d actual %0d",
                        $time, want.smoothed, $signed(rsp_smoothed));
            end
            if (rsp_last_of_frame !== want.last_of_frame) begin
               errors++;
               $display("%0t: last_of_frame expected %0b actual %0b",
                        $time, want.last_of_frame, rsp_last_of_frame);
            end
         end
      end
   end

   // watchdog: cycles with no item moving on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results pending",
                  $time, idle_cycles, smoothed_q.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_frame_end = 1'b0;
      csr_valid = 1'b0;
      csr_gain = '0;
      gain_k = GAIN_ONE / 2;
      held_x = '0;
      held_ok = 1'b0;
      held_first = 1'b1;
      last_y = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_gain_frames();
      test_gain_extremes();
      test_random_frames();
      test_output_backpressure();
      test_full_rate();

      if (smoothed_q.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $time, smoothed_q.size());
      end
      $display("run: %0d samples in %0d frames, %0d smoothed items out", items_in,
               frames_sent, results_out);
      $display("run: %0d gain writes incl. zero, one and clamped, %0d errors",
               gain_writes, errors);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
